[design/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the lookahead processor selection engine.
// ----------------------------------------------------------------------------
package lps_pkg;

    // Operation codes carried in the input transaction.
    typedef enum logic [2:0] {
        OP_COMM      = 3'd0,
        OP_COMP      = 3'd1,
        OP_LOOKAHEAD = 3'd2,
        OP_WEIGHT    = 3'd3,
        OP_AVAIL     = 3'd4,
        OP_ENTRY     = 3'd5,
        OP_SCHED     = 3'd6,
        OP_NOP       = 3'd7
    } t_opcode;

    // Configuration register indexes.
    localparam logic [1:0] REG_TASK_COUNT = 2'd0;
    localparam logic [1:0] REG_PROC_COUNT = 2'd1;
    localparam logic [1:0] REG_ENTRY_TASK = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_EVAL,
        ST_MUL,
        ST_CMP,
        ST_COMMIT,
        ST_OUT
    } t_state;

    localparam int COMM_BITS = 17;
    localparam logic [COMM_BITS-1:0] NO_EDGE = '1;

endpackage

[design/lookahead_processor_selection.sv]
// ----------------------------------------------------------------------------
// lookahead_processor_selection
// List-scheduling processor selection with lookahead and entry duplication.
// ----------------------------------------------------------------------------
// Usage: load transactions (opcodes 0..5) arrive on the slave stream and fill
// the cost tables, processor availability and entry placement; they give no
// result. A schedule transaction (opcode 6) scans, for every processor, all
// predecessors through one shared add/compare unit, one predecessor per cycle,
// then forms finish*10 + lookahead*weight and keeps the first minimum. The
// result appears on the master stream and is held while the receiver stalls;
// the next input is taken only once the result has gone. Reset clears
// availability, duplication flags and the placement table (valid bits) at
// once; the cost memories are undefined until written. Configuration writes
// must go in while the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lookahead_processor_selection #(
    parameter int MAX_TASKS = 64,
    parameter int MAX_PROCS = 8,
    parameter int TIME_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], row[8:3], col[14:9], value[39:15], value_b[63:40],
    // dup_flag[64], zero fill [71:65]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // placed_task[5:0], start_time[29:6], finish_time[53:30],
    // chosen_proc[56:54], saturated[57], zero fill [63:58]
    output logic [63:0] m_axis_tdata
);
    import lps_pkg::*;

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int QW = $clog2(MAX_PROCS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam int MW = TIME_BITS + 30;

    // Configuration registers.
    logic [6:0] r_task_count;
    logic [3:0] r_proc_count;
    logic [5:0] r_entry_task;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= 7'd64;
            r_proc_count <= 4'd8;
            r_entry_task <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TASK_COUNT: r_task_count <= i_cfg_data;
                REG_PROC_COUNT: r_proc_count <= i_cfg_data[3:0];
                REG_ENTRY_TASK: r_entry_task <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Input fields.
    t_opcode            w_op;
    logic [5:0]         w_row, w_col;
    logic signed [24:0] w_val;
    logic [23:0]        w_vb;
    logic               w_dup;
    assign w_op  = t_opcode'(s_axis_tdata[2:0]);
    assign w_row = s_axis_tdata[8:3];
    assign w_col = s_axis_tdata[14:9];
    assign w_val = s_axis_tdata[39:15];
    assign w_vb  = s_axis_tdata[63:40];
    assign w_dup = s_axis_tdata[64];

    // Latched transaction.
    t_opcode            r_op;
    logic [5:0]         r_row, r_col;
    logic signed [24:0] r_val;
    logic [23:0]        r_vb;
    logic               r_dup;

    // Clipping helpers for stored values.
    function automatic logic [23:0] clip24(input logic signed [24:0] v, input logic [23:0] hi);
        logic [23:0] m;
        m = v[23:0];
        if (v[24]) return 24'd0;
        if (m > hi) return hi;
        return m;
    endfunction

    function automatic logic [TIME_BITS-1:0] clipt(input logic [24:0] v);
        logic [63:0] m;
        m = 64'(v);
        if (m > 64'(TMAX)) return TMAX;
        return TIME_BITS'(v);
    endfunction

    // Cost memories.
    logic [COMM_BITS-1:0] m_comm [MAX_TASKS*MAX_TASKS];
    logic [15:0]          m_comp [MAX_TASKS*MAX_PROCS];
    logic [23:0]          m_look [MAX_TASKS*MAX_PROCS];
    logic [3:0]           m_wgt  [MAX_TASKS*MAX_PROCS];
    // Task placement memory with valid bits.
    logic [TIME_BITS-1:0] m_tfin [MAX_TASKS];
    logic [PW-1:0]        m_tproc[MAX_TASKS];
    logic [MAX_TASKS-1:0] r_tvalid;

    logic [TIME_BITS-1:0] r_avail [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_edup;

    t_state r_state, n_state;
    logic [CW-1:0] r_k;
    logic [QW-1:0] r_j;
    logic [QW-1:0] w_p;
    logic [CW-1:0] w_n;
    logic          w_rok, w_pok, w_cok;

    assign w_rok = 32'(r_row) < MAX_TASKS;
    assign w_pok = 32'(r_col) < MAX_PROCS;
    assign w_cok = 32'(r_col) < MAX_TASKS;
    assign w_n = (32'(r_task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(r_task_count);
    always_comb begin
        if (32'(r_proc_count) > MAX_PROCS) w_p = QW'(MAX_PROCS);
        else if (r_proc_count == 4'd0)     w_p = QW'(1);
        else                               w_p = QW'(r_proc_count);
    end

    // Registered memory reads.
    logic [COMM_BITS-1:0] r_c;
    logic [TIME_BITS-1:0] r_fk;
    logic [PW-1:0]        r_pk;
    logic                 r_vk;
    logic [CW-1:0]        r_kd;
    logic                 r_rd_ok;
    logic [15:0]          r_comp_j;
    logic [23:0]          r_look_j;
    logic [3:0]           r_wgt_j;
    logic [TW-1:0]        w_kidx;
    logic [TW+PW-1:0]     w_pidx;
    assign w_kidx = r_k[TW-1:0];
    assign w_pidx = (TW+PW)'(r_row) * (TW+PW)'(MAX_PROCS) + (TW+PW)'(r_j);

    // Scan accumulators.
    logic [TIME_BITS-1:0] r_est, r_eft, r_best_s, r_best_f;
    logic [PW-1:0]        r_best_p;
    logic [MW-1:0]        r_metric, r_best_m;
    logic                 r_have, r_sat;

    // Metric terms: finish times ten and lookahead times weight.
    logic [TIME_BITS+3:0] w_eft10;
    logic [27:0]          w_lw;
    assign w_eft10 = (TIME_BITS+4)'(r_eft) * (TIME_BITS+4)'(10);
    assign w_lw    = 28'(r_look_j) * 28'(r_wgt_j);

    // Shared saturating add: arrival during scan, finish during evaluation.
    logic [TIME_BITS-1:0] w_add_a, w_add_b, w_add_s;
    logic                 w_add_ovf;
    logic [TIME_BITS:0]   w_sum;
    logic                 w_local;
    logic [TIME_BITS-1:0] w_fk;
    logic [PW-1:0]        w_pk;
    assign w_fk = r_vk ? r_fk : '0;
    assign w_pk = r_vk ? r_pk : '0;
    assign w_local = (32'(w_pk) == 32'(r_j)) ||
                     ((32'(r_kd) == 32'(r_entry_task)) && r_edup[r_j[PW-1:0]]);
    always_comb begin
        if (r_state == ST_EVAL) begin
            w_add_a = (r_avail[r_j[PW-1:0]] > r_est) ? r_avail[r_j[PW-1:0]] : r_est;
            w_add_b = TIME_BITS'(r_comp_j);
        end else begin
            w_add_a = w_fk;
            w_add_b = w_local ? '0 : TIME_BITS'(r_c);
        end
        w_sum = {1'b0, w_add_a} + {1'b0, w_add_b};
        w_add_ovf = w_sum[TIME_BITS];
        w_add_s = w_add_ovf ? TMAX : w_sum[TIME_BITS-1:0];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_READ;
            ST_READ:   n_state = (r_op == OP_SCHED && w_rok) ? ST_SCAN : ST_IDLE;
            ST_SCAN:   if (!r_rd_ok && r_k >= w_n) n_state = ST_EVAL;
            ST_EVAL:   n_state = ST_MUL;
            ST_MUL:    n_state = ST_CMP;
            ST_CMP:    n_state = (r_j + QW'(1) >= w_p) ? ST_COMMIT : ST_SCAN;
            ST_COMMIT: n_state = ST_OUT;
            ST_OUT:    if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = (r_state == ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Latch the transaction on acceptance.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= w_op; r_row <= w_row; r_col <= w_col;
            r_val <= w_val; r_vb <= w_vb; r_dup <= w_dup;
        end
    end

    // Table loads happen in the read state.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && w_rok) begin
            if (r_op == OP_COMM && w_cok)
                m_comm[(TW+TW)'(r_row) * (TW+TW)'(MAX_TASKS) + (TW+TW)'(r_col)] <=
                    r_val[24] ? NO_EDGE : {1'b0, 16'(clip24(r_val, 24'hFFFF))};
            if (r_op == OP_COMP && w_pok)
                m_comp[(TW+PW)'(r_row) * (TW+PW)'(MAX_PROCS) + (TW+PW)'(r_col)] <=
                    16'(clip24(r_val, 24'hFFFF));
            if (r_op == OP_LOOKAHEAD && w_pok)
                m_look[(TW+PW)'(r_row) * (TW+PW)'(MAX_PROCS) + (TW+PW)'(r_col)] <=
                    clip24(r_val, 24'hFFFFFF);
            if (r_op == OP_WEIGHT && w_pok)
                m_wgt[(TW+PW)'(r_row) * (TW+PW)'(MAX_PROCS) + (TW+PW)'(r_col)] <=
                    4'(clip24(r_val, 24'd15));
        end
    end

    // Per-processor table reads, one pass per processor.
    always_ff @(posedge i_clk) begin
        r_comp_j <= m_comp[w_pidx];
        r_look_j <= m_look[w_pidx];
        r_wgt_j  <= m_wgt[w_pidx];
        r_c      <= m_comm[(TW+TW)'(w_kidx) * (TW+TW)'(MAX_TASKS) + (TW+TW)'(r_row)];
        r_fk     <= m_tfin[w_kidx];
        r_pk     <= m_tproc[w_kidx];
    end

    // Scan datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else begin
            unique case (r_state)
                ST_READ: begin
                    r_j <= '0; r_k <= '0; r_est <= '0; r_rd_ok <= 1'b0;
                    r_have <= 1'b0; r_sat <= 1'b0;
                end
                ST_SCAN: begin
                    if (r_rd_ok && r_c != NO_EDGE) begin
                        if (w_add_ovf) r_sat <= 1'b1;
                        if (w_add_s > r_est) r_est <= w_add_s;
                    end
                    r_rd_ok <= (r_k < w_n);
                    r_vk    <= r_tvalid[w_kidx];
                    r_kd    <= r_k;
                    if (r_k < w_n) r_k <= r_k + CW'(1);
                end
                ST_EVAL: begin
                    r_est <= w_add_a;
                    r_eft <= w_add_s;
                    if (w_add_ovf) r_sat <= 1'b1;
                end
                ST_MUL: begin
                    r_metric <= MW'(w_eft10) + MW'(w_lw);
                end
                ST_CMP: begin
                    if (!r_have || r_metric < r_best_m) begin
                        r_have <= 1'b1; r_best_m <= r_metric;
                        r_best_s <= r_est; r_best_f <= r_eft;
                        r_best_p <= r_j[PW-1:0];
                    end
                    r_j <= r_j + QW'(1); r_k <= '0; r_est <= '0; r_rd_ok <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Placement table, availability and duplication flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
            r_edup   <= '0;
            for (int i = 0; i < MAX_PROCS; i++) r_avail[i] <= '0;
        end else if (r_state == ST_READ && r_op == OP_AVAIL && w_pok) begin
            r_avail[r_col[PW-1:0]] <= clipt(r_val[24] ? 25'd0 : r_val);
            r_edup[r_col[PW-1:0]]  <= r_dup;
        end else if (r_state == ST_READ && r_op == OP_ENTRY && w_pok &&
                     32'(r_entry_task) < MAX_TASKS) begin
            m_tfin[r_entry_task[TW-1:0]]  <= clipt({1'b0, r_vb});
            m_tproc[r_entry_task[TW-1:0]] <= r_col[PW-1:0];
            r_tvalid[r_entry_task[TW-1:0]] <= 1'b1;
        end else if (r_state == ST_COMMIT) begin
            m_tfin[r_row[TW-1:0]]  <= r_best_f;
            m_tproc[r_row[TW-1:0]] <= r_best_p;
            r_tvalid[r_row[TW-1:0]] <= 1'b1;
            r_avail[r_best_p] <= r_best_f;
        end
    end

    // Result transaction.
    assign m_axis_tdata = {6'd0, r_sat, 3'(r_best_p), 24'(r_best_f), 24'(r_best_s), r_row};

endmodule

[design/lps_checker.sv]
// ----------------------------------------------------------------------------
// lps_checker
// Port-level checks for the lookahead processor selection engine.
// ----------------------------------------------------------------------------
module lps_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    // No input is taken while a result is pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input ready with result pending");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Accepting an input drops ready on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after acceptance");

    // Zero fill bits stay zero.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:58] == 6'd0) else $error("fill bits set");
endmodule

bind lookahead_processor_selection lps_port_checks u_lps_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

[tb/sv/lps_checker.sv]
// ----------------------------------------------------------------------------
// lps_checker
// Watches the configuration port and both streams of the processor selection
// engine. It keeps its own copy of the schedule tables, works out each
// placement and compares it field by field with the output stream.
// ----------------------------------------------------------------------------
module lps_checker
    import lps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [71:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 64;
    localparam int NP = 8;
    localparam logic [23:0] TMAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [5:0]  placed_task;
        logic [23:0] start_time;
        logic [23:0] finish_time;
        logic [2:0]  chosen_proc;
        logic        saturated;
    } t_placement;

    // Mirror of the engine's tables and registers.
    logic [16:0] edge_cost   [NT*NT];
    logic [15:0] exec_cost   [NT*NP];
    logic [23:0] ahead_cost  [NT*NP];
    logic [3:0]  ahead_wt    [NT*NP];
    logic [23:0] proc_free   [NP];
    logic        proc_dup    [NP];
    logic [23:0] t_start     [NT];
    logic [23:0] t_finish    [NT];
    logic [2:0]  t_proc      [NT];
    logic [6:0]  n_tasks;
    logic [3:0]  n_procs;
    logic [5:0]  entry_id;

    t_placement placements_due[$];
    int         mismatches;

    assign o_fail_count = mismatches;

    // Clip a signed load value into [0, hi].
    function automatic logic [23:0] clip_val(logic signed [24:0] v, logic [23:0] hi);
        if (v < 0) return 24'd0;
        if (v[23:0] > hi) return hi;
        return v[23:0];
    endfunction

    // Saturating time sum; raises the flag when clipped.
    function automatic logic [23:0] add_time(logic [23:0] a, logic [23:0] b, ref bit sat);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, TMAX}) begin
            sat = 1'b1;
            return TMAX;
        end
        return s[23:0];
    endfunction

    // Choose the processor for one task and record the placement.
    function automatic t_placement place_task(logic [5:0] tid);
        int          n;
        int          p;
        int          idx;
        logic [23:0] est;
        logic [23:0] eft;
        logic [23:0] arr;
        longint      metric;
        longint      best_m;
        bit          sat;
        bit          have;
        t_placement  res;
        n = (n_tasks > NT) ? NT : n_tasks;
        p = (n_procs > NP) ? NP : n_procs;
        if (p == 0) p = 1;
        sat  = 0;
        have = 0;
        best_m = 0;
        res  = '0;
        for (int j = 0; j < p; j++) begin
            est = 24'd0;
            idx = tid * NP + j;
            for (int k = 0; k < n; k++) begin
                if (edge_cost[k*NT + tid] == NO_EDGE) continue;
                if (t_proc[k] == j || (k == entry_id && proc_dup[j]))
                    arr = t_finish[k];
                else
                    arr = add_time(t_finish[k], {8'd0, edge_cost[k*NT + tid][15:0]}, sat);
                if (arr > est) est = arr;
            end
            if (proc_free[j] > est) est = proc_free[j];
            eft = add_time(est, {8'd0, exec_cost[idx]}, sat);
            metric = longint'(eft) * 10 + longint'(ahead_cost[idx]) * longint'(ahead_wt[idx]);
            if (!have || metric < best_m) begin
                have = 1;
                best_m = metric;
                res.start_time  = est;
                res.finish_time = eft;
                res.chosen_proc = j[2:0];
            end
        end
        res.placed_task = tid;
        res.saturated   = sat;
        t_start[tid]  = res.start_time;
        t_finish[tid] = res.finish_time;
        t_proc[tid]   = res.chosen_proc;
        proc_free[res.chosen_proc] = res.finish_time;
        return res;
    endfunction

    // Apply one accepted input transaction to the mirror.
    task automatic apply_item(logic [71:0] d);
        t_opcode            op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [24:0] val;
        logic [23:0]        vb;
        logic               dup;
        op  = t_opcode'(d[2:0]);
        row = d[8:3];
        col = d[14:9];
        val = d[39:15];
        vb  = d[63:40];
        dup = d[64];
        case (op)
            OP_COMM: begin
                edge_cost[row*NT + col] = (val < 0) ? NO_EDGE
                                                    : {1'b0, 16'(clip_val(val, 24'd65535))};
            end
            OP_COMP:      if (col < NP) exec_cost[row*NP + col] = 16'(clip_val(val, 24'd65535));
            OP_LOOKAHEAD: if (col < NP) ahead_cost[row*NP + col] = clip_val(val, TMAX);
            OP_WEIGHT:    if (col < NP) ahead_wt[row*NP + col] = 4'(clip_val(val, 24'd15));
            OP_AVAIL: begin
                if (col < NP) begin
                    proc_free[col] = clip_val(val, TMAX);
                    proc_dup[col]  = dup;
                end
            end
            OP_ENTRY: begin
                if (col < NP) begin
                    t_start[entry_id]  = clip_val(val, TMAX);
                    t_finish[entry_id] = vb;
                    t_proc[entry_id]   = col[2:0];
                end
            end
            OP_SCHED: placements_due.push_back(place_task(row));
            default: ;
        endcase
    endtask

    // Compare one output transaction with the oldest placement due.
    task automatic check_result(logic [63:0] d);
        t_placement got;
        t_placement want;
        got.placed_task = d[5:0];
        got.start_time  = d[29:6];
        got.finish_time = d[53:30];
        got.chosen_proc = d[56:54];
        got.saturated   = d[57];
        if (placements_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected placement task %0d", $realtime, got.placed_task);
            return;
        end
        want = placements_due.pop_front();
        if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: placement mismatch: expected task %0d start %0d finish %0d",
                         $realtime, want.placed_task, want.start_time, want.finish_time);
                $display("    proc %0d sat %0d, got task %0d start %0d finish %0d",
                         want.chosen_proc, want.saturated, got.placed_task,
                         got.start_time, got.finish_time);
                $display("    proc %0d sat %0d", got.chosen_proc, got.saturated);
            end
        end
    endtask

    initial begin
        mismatches = 0;
        o_pending  = 0;
    end

    // Sample everything at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (proc_free[j]) begin
                proc_free[j] = '0;
                proc_dup[j]  = 1'b0;
            end
            foreach (t_start[k]) begin
                t_start[k]  = '0;
                t_finish[k] = '0;
                t_proc[k]   = '0;
            end
            n_tasks  = 7'd64;
            n_procs  = 4'd8;
            entry_id = 6'd0;
            placements_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TASK_COUNT: n_tasks  = i_cfg_data;
                    REG_PROC_COUNT: n_procs  = i_cfg_data[3:0];
                    REG_ENTRY_TASK: entry_id = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) apply_item(i_in_data);
        end
        o_pending = placements_due.size();
    end

endmodule

[tb/sv/lookahead_processor_selection_test.sv]
// ----------------------------------------------------------------------------
// lookahead_processor_selection_test
// Drives table loads and schedule transactions into the engine under several
// register settings and idle patterns; the checker judges every placement.
// ----------------------------------------------------------------------------
module lookahead_processor_selection_test;
    import lps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RANDOM_ITEMS   = 380;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int placements_seen = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    lookahead_processor_selection u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lps_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus one long hold-off that backs up the input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && placements_seen >= 40) begin
            hold_done = 1;
            hold_left = 3000;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Count transactions and watch for a hang.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) placements_seen++;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one input transaction and wait until it is taken.
    task automatic send_item(t_opcode op, logic [5:0] row, logic [5:0] col,
                             logic [24:0] val, logic [23:0] vb, logic dup);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, dup, vb, val, col, row, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Write registers only once the engine has drained.
    task automatic set_regs(logic [6:0] tasks, logic [6:0] procs, logic [6:0] entry);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (12) @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= REG_TASK_COUNT; i_cfg_data <= tasks;
        @(negedge i_clk);
        i_cfg_index <= REG_PROC_COUNT; i_cfg_data <= procs;
        @(negedge i_clk);
        i_cfg_index <= REG_ENTRY_TASK; i_cfg_data <= entry;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Load value spread over the corners of the signed field.
    function automatic logic [24:0] pick_value();
        case ($urandom_range(7))
            0: return 25'h1FF_FFFF;
            1: return {1'b1, 24'($urandom)};
            2: return 25'd0;
            3: return 25'($urandom_range(100));
            4: return 25'($urandom_range(70000));
            5: return 25'hFF_FFFF - 25'($urandom_range(2000));
            default: return {1'b0, 24'($urandom)};
        endcase
    endfunction

    function automatic logic [5:0] pick_proc();
        if ($urandom_range(7) == 0) return 6'($urandom);
        return 6'($urandom_range(7));
    endfunction

    // Tasks that schedules place: the lowest seven and the top index.
    function automatic logic [5:0] pick_row();
        int r;
        r = $urandom_range(7);
        if (r == 7) return 6'd63;
        return 6'(r);
    endfunction

    // One random transaction, weighted toward schedules.
    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 32)
            send_item(OP_SCHED, pick_row(), 6'($urandom), 25'($urandom), 24'($urandom), 1'($urandom));
        else if (r < 50)
            send_item(OP_COMM, 6'($urandom), 6'($urandom), pick_value(), 24'($urandom), 1'($urandom));
        else if (r < 58)
            send_item(OP_COMP, 6'($urandom), pick_proc(), pick_value(), 24'($urandom), 1'($urandom));
        else if (r < 66)
            send_item(OP_LOOKAHEAD, 6'($urandom), pick_proc(), pick_value(), 24'($urandom), 1'($urandom));
        else if (r < 74)
            send_item(OP_WEIGHT, 6'($urandom), pick_proc(), pick_value(), 24'($urandom), 1'($urandom));
        else if (r < 86)
            send_item(OP_AVAIL, 6'($urandom), pick_proc(), pick_value(), 24'($urandom), 1'($urandom));
        else if (r < 95)
            send_item(OP_ENTRY, 6'($urandom), pick_proc(), pick_value(), 24'($urandom), 1'($urandom));
        else
            send_item(OP_NOP, 6'($urandom), 6'($urandom), 25'($urandom), 24'($urandom), 1'($urandom));
    endtask

    initial begin
        logic [5:0] dst;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every table entry that a schedule can read.
        for (int r = 0; r < 8; r++) begin
            dst = (r == 7) ? 6'd63 : 6'(r);
            for (int s = 0; s < 64; s++)
                send_item(OP_COMM, 6'(s), dst,
                          ($urandom_range(99) < 70) ? 25'h1FF_FFFF : 25'($urandom_range(500)),
                          '0, 1'b0);
            for (int p = 0; p < 8; p++) begin
                send_item(OP_COMP, dst, 6'(p), 25'($urandom_range(300)), '0, 1'b0);
                send_item(OP_LOOKAHEAD, dst, 6'(p), 25'($urandom_range(2000)), '0, 1'b0);
                send_item(OP_WEIGHT, dst, 6'(p), 25'($urandom_range(15)), '0, 1'b0);
            end
        end

        // Directed corners: clipping, ignored indexes, duplication, saturation.
        send_item(OP_COMM, 6'd1, 6'd5, 25'd0, '0, 1'b0);
        send_item(OP_COMM, 6'd2, 6'd5, 25'd70000, '0, 1'b0);
        send_item(OP_COMM, 6'd0, 6'd5, 25'h0FF_FFFF, '0, 1'b0);
        send_item(OP_COMM, 6'd3, 6'd5, 25'h1FF_FFFF, '0, 1'b0);
        send_item(OP_COMP, 6'd5, 6'd0, 25'h100_0000, '0, 1'b0);
        send_item(OP_COMP, 6'd5, 6'd1, 25'd70000, '0, 1'b0);
        send_item(OP_COMP, 6'd5, 6'd9, 25'd7, '0, 1'b0);
        send_item(OP_LOOKAHEAD, 6'd5, 6'd2, 25'h0FF_FFFF, '0, 1'b0);
        send_item(OP_WEIGHT, 6'd5, 6'd2, 25'd200, '0, 1'b0);
        send_item(OP_WEIGHT, 6'd5, 6'd3, 25'd0, '0, 1'b0);
        send_item(OP_ENTRY, 6'd40, 6'd2, 25'h1FF_FFFB, 24'hFF_FFFF, 1'b0);
        send_item(OP_ENTRY, 6'd40, 6'd12, 25'd3, 24'd3, 1'b0);
        send_item(OP_AVAIL, 6'd0, 6'd0, 25'h0FF_FFFF, '0, 1'b1);
        send_item(OP_AVAIL, 6'd0, 6'd3, 25'd10, '0, 1'b1);
        send_item(OP_AVAIL, 6'd0, 6'd63, 25'd5, '0, 1'b1);
        send_item(OP_SCHED, 6'd5, 6'd0, '0, '0, 1'b0);
        send_item(OP_SCHED, 6'd63, 6'd0, '0, '0, 1'b0);
        send_item(OP_NOP, 6'd5, 6'd0, '0, '0, 1'b0);
        send_item(OP_AVAIL, 6'd0, 6'd0, 25'd0, '0, 1'b0);
        send_item(OP_SCHED, 6'd0, 6'd63, 25'h1FF_FFFF, 24'hFF_FFFF, 1'b1);

        // Random phases under different register settings and idle patterns.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_ITEMS == 0) begin
                case (i / PHASE_ITEMS)
                    0: set_regs(7'd64, 7'd8, 7'd0);
                    1: set_regs(7'd1, 7'd1, 7'd63);
                    2: set_regs(7'd0, 7'd0, 7'($urandom_range(63)));
                    3: set_regs(7'd127, 7'd15, 7'($urandom_range(63)));
                    default: set_regs(7'($urandom_range(1, 20)), 7'($urandom_range(1, 8)),
                                      7'($urandom_range(19)));
                endcase
            end
            if (i < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 16; rx_idle_pct = 60;
            end else if (i < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 60; rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            send_random();
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (600) @(posedge i_clk);
        $display("Covered table loads with clipping and ignored indexes, entry duplication,");
        $display("saturating schedules and %0d placements over five register settings.",
                 placements_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
